### rtl/core/tbcd_imsi_decoder_defines.svh
// Assertion macros shared by the identity decoder checker.
// Needs a clock named clk and a reset named rst in the scope of each use.
`ifndef TBCD_IMSI_DECODER_DEFINES_SVH
`define TBCD_IMSI_DECODER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TBCD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tbcd check failed");

// Next-cycle implication, disabled during reset.
`define TBCD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tbcd check failed");

`endif

### rtl/core/tbcd_pkg.sv
// Shared types and constants of the identity (IMSI) TBCD decoder.
// No dependencies; every module of the block imports it.
package tbcd_pkg;

  localparam int DATA_W      = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int STATUS_W    = 3;
  localparam int COUNT_W     = 5;
  localparam int PACKED_W    = 60;
  localparam int INDEX_W     = 17;
  localparam int LEN_W       = 16;
  localparam int OUT_TDATA_W = 72;

  localparam logic [COUNT_W-1:0] COUNT_SAT = 5'd16;
  localparam logic [3:0]         DIGIT_MAX = 4'd9;
  localparam logic [3:0]         FILLER    = 4'hF;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_TYPE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DIGITS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIGITS    = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_SHORT     = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_TYPE  = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_SIZE      = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_BAD_DIGIT = 3'd4;
  localparam logic [STATUS_W-1:0] STATUS_COUNT     = 3'd5;

  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic              last_byte;
  } tbcd_beat_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  digit_count;
    logic [PACKED_W-1:0] digits_packed;
  } tbcd_result_t;

endpackage

### rtl/core/tbcd_imsi_decoder.sv
// Decodes one IMSI element streamed one byte per beat (type, two length bytes, a spare byte,
// then TBCD digit pairs low nibble first) and emits one result beat on the byte marked tlast.
// A byte beat is accepted every cycle unless a last byte waits in the input register for a held
// result; a result beat is registered in the result register after its last byte has passed
// the input register. A held result does not block digit bytes, only the next last byte.
// Configuration is to be written only while the stream is idle; the block does not enforce it.
module tbcd_imsi_decoder #(
  parameter int MAX_DIGITS = 15
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [tbcd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tbcd_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [tbcd_pkg::DATA_W-1:0]          s_axis_tdata,  // [7:0] data_byte
  input  logic                                 s_axis_tlast,  // last_byte
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [2:0] status, [7:3] digit_count, [67:8] digits_packed, [71:68] zero
  output logic [tbcd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
  import tbcd_pkg::*;

  tbcd_beat_t   s_beat;
  tbcd_beat_t   in_beat;
  tbcd_result_t res;
  logic         in_valid;
  logic         take;

  assign s_beat.data_byte = s_axis_tdata;
  assign s_beat.last_byte = s_axis_tlast;

  tbcd_in_stage u_in_stage (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .s_beat  (s_beat),
    .valid   (in_valid),
    .beat    (in_beat),
    .take    (take)
  );

  tbcd_core #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_beat   (in_beat),
    .take      (take),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res       (res)
  );

  assign m_axis_tdata = {4'b0, res.digits_packed, res.digit_count, res.status};

endmodule

### rtl/core/tbcd_in_stage.sv
// Input register of the identity decoder: holds one byte beat until the core takes it.
// Depends on tbcd_pkg.
module tbcd_in_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_valid,
  output logic                 s_ready,
  input  tbcd_pkg::tbcd_beat_t s_beat,
  output logic                 valid,
  output tbcd_pkg::tbcd_beat_t beat,
  input  logic                 take
);
  import tbcd_pkg::*;

  logic valid_next;

  assign s_ready = !valid || take;

  always_comb begin
    valid_next = valid;
    if (s_valid && s_ready) begin
      valid_next = 1'b1;
    end else if (take) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      beat <= s_beat;
    end
  end

endmodule

### rtl/core/tbcd_core.sv
// Element state, digit decode and result register of the identity decoder.
// Depends on tbcd_pkg.
module tbcd_core #(
  parameter int MAX_DIGITS = 15
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [tbcd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tbcd_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  input  tbcd_pkg::tbcd_beat_t               in_beat,
  output logic                               take,
  output logic                               res_valid,
  input  logic                               res_ready,
  output tbcd_pkg::tbcd_result_t             res
);
  import tbcd_pkg::*;

  localparam int STORE_W = 4 * MAX_DIGITS;

  logic [7:0] expected_type;
  logic [3:0] min_digits;
  logic [3:0] max_digits;

  logic [INDEX_W-1:0] byte_index, byte_index_next;
  logic [7:0]         type_seen, type_seen_next;
  logic [LEN_W-1:0]   declared_len, declared_len_next;
  logic [STORE_W-1:0] digit_store, digit_store_next;
  logic [COUNT_W-1:0] digits_held, digits_held_next;
  logic               filler_seen, filler_seen_next;
  logic               digit_fault, digit_fault_next;

  logic [3:0]          lo_nib, hi_nib;
  logic [STORE_W-1:0]  store_mid;
  logic [COUNT_W-1:0]  held_mid;
  logic [STATUS_W-1:0] status_next;
  logic                emit;

  // A non-last byte never needs the result register, so it moves on regardless.
  assign take = in_valid && (!in_beat.last_byte || !res_valid || res_ready);
  assign emit = take && in_beat.last_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_type <= 8'd1;
      min_digits    <= 4'd6;
      max_digits    <= 4'd15;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_EXPECTED_TYPE: expected_type <= cfg_data;
        REG_MIN_DIGITS:    min_digits    <= cfg_data[3:0];
        REG_MAX_DIGITS:    max_digits    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    lo_nib            = in_beat.data_byte[3:0];
    hi_nib            = in_beat.data_byte[7:4];
    type_seen_next    = type_seen;
    declared_len_next = declared_len;
    digit_store_next  = digit_store;
    digits_held_next  = digits_held;
    filler_seen_next  = filler_seen;
    digit_fault_next  = digit_fault;
    store_mid         = digit_store;
    held_mid          = digits_held;

    if (byte_index == '0) begin
      type_seen_next = in_beat.data_byte;
    end else if (byte_index == INDEX_W'(1)) begin
      declared_len_next = {in_beat.data_byte, declared_len[7:0]};
    end else if (byte_index == INDEX_W'(2)) begin
      declared_len_next = {declared_len[15:8], in_beat.data_byte};
    end else if (byte_index >= INDEX_W'(4) && !filler_seen && !digit_fault) begin
      if (lo_nib > DIGIT_MAX) begin
        digit_fault_next = 1'b1;
      end else begin
        // Low digit first, then the high digit in the next nibble slot.
        for (int i = 0; i < MAX_DIGITS; i++) begin
          if (digits_held == COUNT_W'(i)) begin
            store_mid[4*i +: 4] = lo_nib;
          end
        end
        held_mid         = (digits_held < COUNT_SAT) ? digits_held + 1'b1 : digits_held;
        digit_store_next = store_mid;
        digits_held_next = held_mid;
        if (hi_nib <= DIGIT_MAX) begin
          for (int i = 0; i < MAX_DIGITS; i++) begin
            if (held_mid == COUNT_W'(i)) begin
              digit_store_next[4*i +: 4] = hi_nib;
            end
          end
          digits_held_next = (held_mid < COUNT_SAT) ? held_mid + 1'b1 : held_mid;
        end else if (hi_nib == FILLER) begin
          filler_seen_next = 1'b1;
        end else begin
          digit_fault_next = 1'b1;
        end
      end
    end

    byte_index_next = (byte_index != '1) ? byte_index + 1'b1 : byte_index;
  end

  always_comb begin
    if (byte_index_next < INDEX_W'(4)) begin
      status_next = STATUS_SHORT;
    end else if (type_seen_next != expected_type) begin
      status_next = STATUS_BAD_TYPE;
    end else if (byte_index_next < ({1'b0, declared_len_next} + INDEX_W'(3))) begin
      status_next = STATUS_SIZE;
    end else if (digit_fault_next) begin
      status_next = STATUS_BAD_DIGIT;
    end else if (digits_held_next > {1'b0, max_digits} ||
                 digits_held_next < {1'b0, min_digits}) begin
      status_next = STATUS_COUNT;
    end else begin
      status_next = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || emit) begin
      byte_index   <= '0;
      type_seen    <= '0;
      declared_len <= '0;
      digit_store  <= '0;
      digits_held  <= '0;
      filler_seen  <= 1'b0;
      digit_fault  <= 1'b0;
    end else if (take) begin
      byte_index   <= byte_index_next;
      type_seen    <= type_seen_next;
      declared_len <= declared_len_next;
      digit_store  <= digit_store_next;
      digits_held  <= digits_held_next;
      filler_seen  <= filler_seen_next;
      digit_fault  <= digit_fault_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res.status        <= status_next;
      res.digit_count   <= digits_held_next;
      res.digits_packed <= PACKED_W'(digit_store_next);
    end
  end

endmodule

### rtl/core/tbcd_imsi_decoder_checker.sv
// Port-level checks of the identity decoder's result stream, bound to the top level.
// Depends on tbcd_pkg and tbcd_imsi_decoder_defines.svh.
`include "tbcd_imsi_decoder_defines.svh"

module tbcd_imsi_decoder_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [tbcd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import tbcd_pkg::*;

  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  digit_count;

  assign status      = m_axis_tdata[2:0];
  assign digit_count = m_axis_tdata[7:3];

  `TBCD_ASSERT_NEXT(a_stall_holds, m_axis_tvalid && !m_axis_tready,
                    m_axis_tvalid && $stable(m_axis_tdata))
  `TBCD_ASSERT_NOW(a_status_code, m_axis_tvalid, status <= STATUS_COUNT)
  `TBCD_ASSERT_NOW(a_count_sat, m_axis_tvalid, digit_count <= COUNT_SAT)
  `TBCD_ASSERT_NOW(a_ok_fits, m_axis_tvalid && status == STATUS_OK, digit_count < COUNT_SAT)
  `TBCD_ASSERT_NOW(a_short_empty, m_axis_tvalid && status == STATUS_SHORT,
                   digit_count == '0 && m_axis_tdata[67:8] == '0)

endmodule

bind tbcd_imsi_decoder tbcd_imsi_decoder_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### dv/tb.sv
// Self-checking bench for the IMSI TBCD decoder: streams identity elements through the byte port,
// predicts each status/count/digit beat in a scoreboard class and checks every result beat.
// Depends on tbcd_pkg and the tbcd_imsi_decoder top level only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tbcd_pkg::*;

  typedef bit [7:0] byte_q_t[$];

  class imsi_scoreboard;
    bit [7:0]      want_type;
    bit [3:0]      min_count;
    bit [3:0]      max_count;
    bit [16:0]     byte_pos;
    bit [7:0]      type_byte;
    bit [15:0]     length_field;
    bit [59:0]     digit_acc;
    bit [4:0]      digit_total;
    bit            hit_filler;
    bit            hit_fault;
    tbcd_result_t  pending_q[$];
    int            errors;

    function new();
      want_type = 8'd1;
      min_count = 4'd6;
      max_count = 4'd15;
      errors    = 0;
      clear_element();
    endfunction

    function void clear_element();
      byte_pos     = '0;
      type_byte    = '0;
      length_field = '0;
      digit_acc    = '0;
      digit_total  = '0;
      hit_filler   = 1'b0;
      hit_fault    = 1'b0;
    endfunction

    function void set_reg(bit [CFG_IDX_W-1:0] idx, bit [7:0] value);
      case (idx)
        REG_EXPECTED_TYPE: want_type = value;
        REG_MIN_DIGITS:    min_count = value[3:0];
        REG_MAX_DIGITS:    max_count = value[3:0];
        default: ;
      endcase
    endfunction

    function void add_digit(bit [3:0] d);
      if (digit_total < 5'd15) digit_acc[int'(digit_total)*4 +: 4] = d;
      if (digit_total < COUNT_SAT) digit_total++;
    endfunction

    // Updates the element state with one accepted byte and queues a result on the last one.
    function void note_beat(bit [7:0] b, bit last);
      tbcd_result_t r;
      bit [3:0] lo;
      bit [3:0] hi;
      lo = b[3:0];
      hi = b[7:4];
      if (byte_pos == 17'd0) begin
        type_byte = b;
      end else if (byte_pos == 17'd1) begin
        length_field[15:8] = b;
      end else if (byte_pos == 17'd2) begin
        length_field[7:0] = b;
      end else if (byte_pos >= 17'd4 && !hit_filler && !hit_fault) begin
        if (lo > DIGIT_MAX) begin
          hit_fault = 1'b1;
        end else begin
          add_digit(lo);
          if (hi <= DIGIT_MAX) add_digit(hi);
          else if (hi == FILLER) hit_filler = 1'b1;
          else hit_fault = 1'b1;
        end
      end
      if (byte_pos != 17'h1FFFF) byte_pos++;
      if (!last) return;
      if (byte_pos < 17'd4) r.status = STATUS_SHORT;
      else if (type_byte != want_type) r.status = STATUS_BAD_TYPE;
      else if (int'(byte_pos) < 3 + int'(length_field)) r.status = STATUS_SIZE;
      else if (hit_fault) r.status = STATUS_BAD_DIGIT;
      else if (digit_total > {1'b0, max_count} || digit_total < {1'b0, min_count})
        r.status = STATUS_COUNT;
      else r.status = STATUS_OK;
      r.digit_count   = digit_total;
      r.digits_packed = digit_acc;
      pending_q = {pending_q, r};
      clear_element();
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [OUT_TDATA_W-1:0] tdata);
      tbcd_result_t want;
      if (pending_q.size() == 0) begin
        report($sformatf("result beat %h with nothing expected", tdata));
        return;
      end
      want = pending_q.pop_front();
      if (tdata[2:0] !== want.status)
        report($sformatf("status %0d, expected %0d", tdata[2:0], want.status));
      if (tdata[7:3] !== want.digit_count)
        report($sformatf("digit_count %0d, expected %0d", tdata[7:3], want.digit_count));
      if (tdata[67:8] !== want.digits_packed)
        report($sformatf("digits %h, expected %h", tdata[67:8], want.digits_packed));
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [DATA_W-1:0]      s_axis_tdata = '0;
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  imsi_scoreboard sb = new();

  int burst_left = 0;
  int phase_beats = 0;
  int stall_left = 0;
  int stall_mode = 0;

  tbcd_imsi_decoder i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result side: check accepted beats, then pick the next tready from the current stall mode.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready) sb.check_result(m_axis_tdata);
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 80);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ~m_axis_tready;
      2: m_axis_tready <= $urandom_range(0, 1);
      default: m_axis_tready <= (stall_left % 8 == 0);
    endcase
  end

  task automatic send_beat(input bit [7:0] b, input bit last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    sb.note_beat(b, last);
    phase_beats++;
  endtask

  task automatic send_elem(input byte_q_t q);
    foreach (q[i]) send_beat(q[i], i == q.size() - 1);
  endtask

  // Waits until every queued result has been seen and the pipeline has drained.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(input bit [7:0] typ, input bit [3:0] lo_cnt, input bit [3:0] hi_cnt);
    bit [7:0] vals[3];
    vals = '{typ, {4'd0, lo_cnt}, {4'd0, hi_cnt}};
    for (int i = 0; i < 3; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= i[CFG_IDX_W-1:0];
      cfg_data  <= vals[i];
      @(posedge clk);
      sb.set_reg(i[CFG_IDX_W-1:0], vals[i]);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic byte_q_t header(bit [7:0] typ, bit [15:0] len);
    byte_q_t q;
    q = '{typ, len[15:8], len[7:0], 8'($urandom)};
    return q;
  endfunction

  // Packs n random digits into TBCD bytes; an odd count ends in a filler high nibble.
  function automatic byte_q_t digit_bytes(int n);
    byte_q_t q;
    bit [7:0] b;
    for (int i = 0; i < n; i += 2) begin
      if (i + 1 < n) b = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
      else b = {FILLER, 4'($urandom_range(0, 9))};
      q = {q, b};
    end
    return q;
  endfunction

  function automatic byte_q_t framed(bit [7:0] typ, byte_q_t body);
    return {header(typ, 16'(body.size() + 1)), body};
  endfunction

  task automatic send_random_elem();
    byte_q_t body;
    byte_q_t q;
    bit [7:0] typ;
    bit [7:0] b;
    int kind;
    int n;
    int pos;
    kind = $urandom_range(0, 9);
    typ = ($urandom_range(0, 7) == 0) ? 8'($urandom) : sb.want_type;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 20) : $urandom_range(0, 16);
    body = digit_bytes(n);
    if (kind <= 5) begin
      if (n % 2 == 1 && $urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) body = {body, 8'($urandom)};
      q = framed(typ, body);
    end else if (kind == 6) begin
      pos = $urandom_range(0, body.size());
      if ($urandom_range(0, 1) == 0) b = {4'($urandom), 4'($urandom_range(10, 15))};
      else b = {4'($urandom_range(10, 14)), 4'($urandom_range(0, 9))};
      body.insert(pos, b);
      q = framed(typ, body);
    end else if (kind == 7) begin
      repeat ($urandom_range(1, 3)) q = {q, 8'($urandom)};
      if ($urandom_range(0, 1) == 0) q[0] = sb.want_type;
    end else if (kind == 8) begin
      q = {header(typ, 16'(body.size() + 1 + $urandom_range(1, 3))), body};
      if ($urandom_range(0, 1) == 0) q[2] = 8'($urandom_range(0, 2));
    end else begin
      repeat ($urandom_range(1, 12)) q = {q, 8'($urandom)};
    end
    send_elem(q);
  endtask

  task automatic run_random(input int beats);
    phase_beats = 0;
    while (phase_beats < beats) send_random_elem();
    settle();
  endtask

  task automatic run_directed();
    // Too short: one, three bytes.
    send_elem('{8'h01});
    send_elem('{8'h01, 8'h00, 8'h01});
    // Header only, no digits: count below the minimum.
    send_elem('{8'h01, 8'h00, 8'h01, 8'hFF});
    // Wrong type, then exact length boundary one byte short.
    send_elem('{8'h00, 8'h00, 8'h02, 8'h00, 8'h21});
    send_elem('{8'h01, 8'h00, 8'h03, 8'h00, 8'h21});
    // Fifteen digits, accepted.
    send_elem(framed(8'h01, '{8'h10, 8'h32, 8'h54, 8'h76, 8'h98, 8'h10, 8'h32, 8'hF9}));
    // Bad low nibble after digits, later bytes ignored.
    send_elem(framed(8'h01, '{8'h99, 8'h00, 8'h0A, 8'h11}));
    // Bad high nibble, and an all-ones byte as a digit byte.
    send_elem(framed(8'h01, '{8'h21, 8'hC3, 8'h55}));
    send_elem(framed(8'h01, '{8'hFF}));
    // Filler ends decoding; a bad byte after it must not matter.
    send_elem(framed(8'h01, '{8'h00, 8'h00, 8'h00, 8'hF0, 8'hFF, 8'hAA}));
    // Eighteen digits: count saturates, only fifteen are stored.
    send_elem(framed(8'h01, '{8'h99, 8'h88, 8'h77, 8'h66, 8'h55, 8'h44, 8'h33, 8'h22, 8'h11}));
    // Declared length smaller than the element: the extra bytes still decode.
    send_elem({header(8'h01, 16'd1), 8'h43, 8'h65, 8'h87, 8'hF9});
    settle();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    run_random(65);
    write_regs(8'h00, 4'd0, 4'd15);
    send_elem('{8'h00, 8'h00, 8'h01, 8'h00});
    run_random(65);
    write_regs(8'hFF, 4'd0, 4'd0);
    send_elem('{8'hFF, 8'hFF, 8'hFF, 8'hFF});
    run_random(65);
    write_regs(8'h5A, 4'd15, 4'd15);
    run_random(65);
    // Minimum above maximum: every count is rejected.
    write_regs(8'h01, 4'd15, 4'd0);
    run_random(65);
    write_regs(8'($urandom), 4'($urandom), 4'($urandom));
    run_random(45);
    write_regs(8'h01, 4'd6, 4'd15);
    run_random(45);
    settle();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/tbcd_pkg.sv
rtl/core/tbcd_in_stage.sv
rtl/core/tbcd_core.sv
rtl/core/tbcd_imsi_decoder.sv
rtl/core/tbcd_imsi_decoder_checker.sv
dv/tb.sv
